FILE: src/kng_pkg.sv
// ----------------------------------------------------------------------------
// kng_pkg
// Shared types and constants of the k-mer neighborhood generator.
// ----------------------------------------------------------------------------
package kng_pkg;

  // Default table and word size limits
  localparam int DEF_MAX_ALPHABET = 32;
  localparam int DEF_MAX_WORD     = 8;

  // Fixed field widths
  localparam int CODE_W   = 40;
  localparam int ESCORE_W = 8;
  localparam int OSCORE_W = 11;
  localparam int CFG_W    = 11;
  localparam int CFGIDX_W = 2;

  // Configuration register indexes
  localparam logic [CFGIDX_W-1:0] CFG_ALPHABET  = 2'd0;
  localparam logic [CFGIDX_W-1:0] CFG_WORD_LEN  = 2'd1;
  localparam logic [CFGIDX_W-1:0] CFG_THRESHOLD = 2'd2;

  // Register reset values
  localparam logic [5:0]         RST_ALPHABET  = 6'd20;
  localparam logic [3:0]         RST_WORD_LEN  = 4'd3;
  localparam logic signed [10:0] RST_THRESHOLD = 11'sd11;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_FETCH = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_LOADED    = 3'd0,
    ST_ACCEPTED  = 3'd1,
    ST_FOUND     = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_REJECTED  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RM_RD,
    S_RM_CHK,
    S_INS_RD,
    S_INS_CHK,
    S_MAX_RD,
    S_MAX_WR,
    S_BEST,
    S_LIM,
    S_DIV,
    S_F_LOAD,
    S_F_TEST,
    S_F_EVAL,
    S_EMIT
  } state_e;

endpackage

FILE: src/kmer_neighborhood_generator.sv
// ----------------------------------------------------------------------------
// kmer_neighborhood_generator
// Substitution table with sorted rows and a pruned depth-first neighbor search.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word per item: a load
//   of one score entry, a query start or a fetch of the next neighbor. Every
//   word yields exactly one result word on the output channel
//   (out_valid_o / out_stall_i). One item is worked on at a time.
//   All work runs through one table memory with one read port. A load
//   removes any earlier entry of the same column, inserts the new entry in
//   order and then sweeps the row maxima to rebuild the table maximum. A
//   query computes the range bound alphabet^word_length and then peels the
//   digits with the bit-serial divider. A fetch resumes the pruned depth-first
//   walk until the next neighbor or the end of the search.
//   Reset clears all row lengths, row maxima and the search state, sets the
//   table maximum to -128 and the configuration registers to their reset
//   values; table contents stay unknown but are never read before written.
//   A stalled result holds in the output register; the next item is taken
//   once the block is back in idle, and its result waits for the slot.
// ----------------------------------------------------------------------------
module kmer_neighborhood_generator #(
  parameter int MAX_ALPHABET = kng_pkg::DEF_MAX_ALPHABET,
  parameter int MAX_WORD     = kng_pkg::DEF_MAX_WORD
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kng_pkg::CFGIDX_W-1:0]      cfg_index_i,
  input  logic [kng_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        in_kind_i,
  input  logic [4:0]                        in_row_symbol_i,
  input  logic [4:0]                        in_column_symbol_i,
  input  logic signed [7:0]                 in_entry_score_i,
  input  logic [kng_pkg::CODE_W-1:0]        in_query_code_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        out_status_o,
  output logic [kng_pkg::CODE_W-1:0]        out_neighbor_code_o,
  output logic signed [kng_pkg::OSCORE_W-1:0] out_neighbor_score_o
);

  localparam int CODE_W    = kng_pkg::CODE_W;
  localparam int ROW_W     = $clog2(MAX_ALPHABET);
  localparam int FILL_W    = $clog2(MAX_ALPHABET + 1);
  localparam int ALPHA_W   = FILL_W;
  localparam int REM_W     = ALPHA_W + 1;
  localparam int DEP_W     = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int WORD_W    = $clog2(MAX_WORD + 1);
  localparam int SUM_W     = $clog2(1024 + MAX_WORD * 128) + 1;
  localparam int PROD_W    = WORD_W + 12;
  localparam int LIM_W     = CODE_W + 2;
  localparam int LIMP_W    = LIM_W + ALPHA_W;
  localparam int BIT_W     = $clog2(CODE_W);
  localparam int MEM_W     = ROW_W + 8;
  localparam int MEM_DEPTH = MAX_ALPHABET * MAX_ALPHABET;
  localparam int ADDR_W    = 2 * ROW_W;
  localparam logic [LIM_W-1:0] LIM_SAT = LIM_W'(1) << (LIM_W - 1);

  // Configuration registers
  logic [5:0]         alph_q;
  logic [3:0]         wlen_q;
  logic signed [10:0] thr_q;

  // Control and working registers
  kng_pkg::state_e state_q, state_d;
  logic [FILL_W-1:0]  fill_q [MAX_ALPHABET];
  logic signed [7:0]  rmax_q [MAX_ALPHABET];
  logic signed [7:0]  best_q, best_d;
  logic [ROW_W-1:0]   digit_q [MAX_WORD];
  logic signed [SUM_W-1:0] pt_q [MAX_WORD];
  logic [FILL_W-1:0]  branch_q [MAX_WORD];
  logic signed [SUM_W-1:0] pscore_q [MAX_WORD];
  logic [CODE_W-1:0]  pcode_q [MAX_WORD];
  logic [DEP_W-1:0]   depth_q, depth_d;
  logic               active_q, active_d;
  logic [ROW_W-1:0]   row_q, row_d, col_q, col_d;
  logic signed [7:0]  s_q, s_d;
  logic [FILL_W-1:0]  n_q, n_d, i_q, i_d;
  logic               found_q, found_d;
  logic [WORD_W-1:0]  k_q, k_d;
  logic [DEP_W-1:0]   pos_q, pos_d;
  logic [LIM_W-1:0]   lim_q, lim_d;
  logic [CODE_W-1:0]  code_q, code_d;
  logic [ALPHA_W-1:0] rem_q, rem_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  kng_pkg::status_e   res_status_q, res_status_d;
  logic [CODE_W-1:0]  res_code_q, res_code_d;
  logic signed [kng_pkg::OSCORE_W-1:0] res_score_q, res_score_d;
  logic               out_valid_q;
  kng_pkg::status_e   out_status_q;
  logic [CODE_W-1:0]  out_code_q;
  logic signed [kng_pkg::OSCORE_W-1:0] out_score_q;

  // Table memory
  logic [MEM_W-1:0]   mem [MEM_DEPTH];
  logic [MEM_W-1:0]   rd_q;
  logic               mem_re, mem_we;
  logic [ADDR_W-1:0]  mem_raddr, mem_waddr;
  logic [MEM_W-1:0]   mem_wdata;

  // Array writes requested by the datapath
  logic               fill_we, rmax_we, dig_we, pt_we, br_we, br1_we, step_we;
  logic [FILL_W-1:0]  fill_wd, br_wd;
  logic [DEP_W-1:0]   dig_idx, pt_idx_w;
  logic signed [SUM_W-1:0] pt_wd;
  logic               q_init;

  // Shared decode
  logic [ALPHA_W-1:0] a_eff;
  logic [WORD_W-1:0]  q_eff;
  logic               acc, slot_free;
  logic [ROW_W-1:0]   fill_addr, rmax_addr, dig_cur, digit_new;
  logic [FILL_W-1:0]  fill_rd;
  logic signed [7:0]  rmax_rd;
  logic [ROW_W-1:0]   rd_col;
  logic signed [7:0]  rd_score;
  logic               load_oob, thr_bad, ins_after, lim_bad, f_over, f_more;
  logic               f_skip, f_hit, f_leaf, div_ge;
  logic signed [PROD_W-1:0] qb;
  logic [LIMP_W-1:0]  lim_prod;
  logic [LIM_W-1:0]   lim_nx;
  logic [REM_W-1:0]   rem2, rem_sub;
  logic [ALPHA_W-1:0] rem_nx;
  logic signed [SUM_W-1:0] ns, pt_idx_rd, mx;
  logic [DEP_W-1:0]   pt_ridx;
  logic [CODE_W+ALPHA_W-1:0] code_prod;
  logic [CODE_W-1:0]  ext_code;

  // Clamp the alphabet and word length registers to their usable ranges
  always_comb begin
    if (alph_q < 6'd2) begin
      a_eff = ALPHA_W'(2);
    end else if (int'(alph_q) > MAX_ALPHABET) begin
      a_eff = ALPHA_W'(MAX_ALPHABET);
    end else begin
      a_eff = ALPHA_W'(alph_q);
    end
    if (wlen_q == 4'd0) begin
      q_eff = WORD_W'(1);
    end else if (int'(wlen_q) > MAX_WORD) begin
      q_eff = WORD_W'(MAX_WORD);
    end else begin
      q_eff = WORD_W'(wlen_q);
    end
  end

  assign acc        = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != kng_pkg::S_IDLE);

  assign rd_col   = rd_q[MEM_W-1 -: ROW_W];
  assign rd_score = $signed(rd_q[7:0]);
  assign dig_cur  = digit_q[depth_q];

  // Bit-serial divider step
  assign rem2      = {rem_q, code_q[CODE_W-1]};
  assign div_ge    = rem2 >= REM_W'(a_eff);
  assign rem_sub   = div_ge ? (rem2 - REM_W'(a_eff)) : rem2;
  assign rem_nx    = rem_sub[ALPHA_W-1:0];
  assign digit_new = rem_nx[ROW_W-1:0];

  // Pick the row addresses of the length and maximum arrays
  always_comb begin
    unique case (state_q)
      kng_pkg::S_IDLE:   fill_addr = ROW_W'(in_row_symbol_i);
      kng_pkg::S_BEST:   fill_addr = i_q[ROW_W-1:0];
      kng_pkg::S_DIV:    fill_addr = digit_new;
      kng_pkg::S_F_TEST: fill_addr = dig_cur;
      default:           fill_addr = row_q;
    endcase
    unique case (state_q)
      kng_pkg::S_BEST: rmax_addr = i_q[ROW_W-1:0];
      kng_pkg::S_DIV:  rmax_addr = digit_new;
      default:         rmax_addr = row_q;
    endcase
  end
  assign fill_rd = fill_q[fill_addr];
  assign rmax_rd = rmax_q[rmax_addr];

  assign pt_ridx   = (state_q == kng_pkg::S_DIV) ? pos_q : depth_q;
  assign pt_idx_rd = pt_q[pt_ridx];
  assign mx        = (fill_rd != '0) ? SUM_W'(rmax_rd) : '0;

  // Conditions
  assign load_oob  = (int'(in_row_symbol_i) >= MAX_ALPHABET) ||
                     (int'(in_column_symbol_i) >= MAX_ALPHABET);
  assign qb        = PROD_W'($signed({1'b0, q_eff})) * PROD_W'(best_q);
  assign thr_bad   = PROD_W'(thr_q) > qb;
  assign ins_after = (rd_score < s_q) || ((rd_score == s_q) && (rd_col > col_q));
  assign lim_prod  = LIMP_W'(lim_q) * LIMP_W'(a_eff);
  assign lim_nx    = (lim_prod > LIMP_W'(LIM_SAT)) ? LIM_SAT : lim_prod[LIM_W-1:0];
  assign lim_bad   = LIM_W'(code_q) >= lim_q;
  assign f_over    = WORD_W'(depth_q) >= q_eff;
  assign f_more    = i_q < fill_rd;
  assign f_skip    = FILL_W'(rd_col) >= a_eff;
  assign ns        = pscore_q[depth_q] + SUM_W'(rd_score);
  assign f_hit     = ns >= pt_idx_rd;
  assign f_leaf    = (WORD_W'(depth_q) + WORD_W'(1)) == q_eff;
  assign code_prod = (CODE_W+ALPHA_W)'(pcode_q[depth_q]) * (CODE_W+ALPHA_W)'(a_eff);
  assign ext_code  = code_prod[CODE_W-1:0] + CODE_W'(rd_col);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kng_pkg::S_IDLE: begin
        if (acc) begin
          priority case (in_kind_i)
            kng_pkg::KIND_LOAD:  state_d = load_oob ? kng_pkg::S_EMIT : kng_pkg::S_RM_RD;
            kng_pkg::KIND_QUERY: state_d = thr_bad ? kng_pkg::S_EMIT : kng_pkg::S_LIM;
            kng_pkg::KIND_FETCH: state_d = active_q ? kng_pkg::S_F_LOAD : kng_pkg::S_EMIT;
            default:             state_d = kng_pkg::S_EMIT;
          endcase
        end
      end
      kng_pkg::S_RM_RD:   state_d = (i_q < n_q) ? kng_pkg::S_RM_CHK : kng_pkg::S_INS_RD;
      kng_pkg::S_RM_CHK:  state_d = kng_pkg::S_RM_RD;
      kng_pkg::S_INS_RD:  state_d = (i_q == '0) ? kng_pkg::S_MAX_RD : kng_pkg::S_INS_CHK;
      kng_pkg::S_INS_CHK: state_d = ins_after ? kng_pkg::S_INS_RD : kng_pkg::S_MAX_RD;
      kng_pkg::S_MAX_RD:  state_d = kng_pkg::S_MAX_WR;
      kng_pkg::S_MAX_WR:  state_d = kng_pkg::S_BEST;
      kng_pkg::S_BEST: begin
        if (int'(i_q) == MAX_ALPHABET - 1) state_d = kng_pkg::S_EMIT;
      end
      kng_pkg::S_LIM: begin
        if (k_q >= q_eff) state_d = lim_bad ? kng_pkg::S_EMIT : kng_pkg::S_DIV;
      end
      kng_pkg::S_DIV: begin
        if (int'(bit_q) == CODE_W - 1 && pos_q == '0) state_d = kng_pkg::S_EMIT;
      end
      kng_pkg::S_F_LOAD: state_d = kng_pkg::S_F_TEST;
      kng_pkg::S_F_TEST: begin
        if (f_over) begin
          state_d = kng_pkg::S_EMIT;
        end else if (f_more) begin
          state_d = kng_pkg::S_F_EVAL;
        end else if (depth_q == '0) begin
          state_d = kng_pkg::S_EMIT;
        end else begin
          state_d = kng_pkg::S_F_LOAD;
        end
      end
      kng_pkg::S_F_EVAL: begin
        if (f_skip) begin
          state_d = kng_pkg::S_F_TEST;
        end else if (f_hit) begin
          state_d = f_leaf ? kng_pkg::S_EMIT : kng_pkg::S_F_LOAD;
        end else if (depth_q == '0) begin
          state_d = kng_pkg::S_EMIT;
        end else begin
          state_d = kng_pkg::S_F_LOAD;
        end
      end
      kng_pkg::S_EMIT: begin
        if (slot_free) state_d = kng_pkg::S_IDLE;
      end
      default: state_d = kng_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    best_d = best_q;   depth_d = depth_q;  active_d = active_q;
    row_d = row_q;     col_d = col_q;      s_d = s_q;
    n_d = n_q;         i_d = i_q;          found_d = found_q;
    k_d = k_q;         pos_d = pos_q;      lim_d = lim_q;
    code_d = code_q;   rem_d = rem_q;      bit_d = bit_q;
    res_status_d = res_status_q; res_code_d = res_code_q; res_score_d = res_score_q;
    mem_re = 1'b0; mem_raddr = {row_q, i_q[ROW_W-1:0]};
    mem_we = 1'b0; mem_waddr = {row_q, i_q[ROW_W-1:0]};
    mem_wdata = {col_q, s_q};
    fill_we = 1'b0; fill_wd = FILL_W'(n_q + FILL_W'(1));
    rmax_we = 1'b0;
    dig_we = 1'b0; dig_idx = pos_q;
    pt_we = 1'b0; pt_idx_w = pos_q; pt_wd = pt_idx_rd - mx;
    br_we = 1'b0; br_wd = i_q; br1_we = 1'b0; step_we = 1'b0;
    q_init = 1'b0;
    unique case (state_q)
      kng_pkg::S_IDLE: begin
        if (acc) begin
          res_code_d  = '0;
          res_score_d = '0;
          priority case (in_kind_i)
            kng_pkg::KIND_LOAD: begin
              active_d     = 1'b0;
              res_status_d = kng_pkg::ST_LOADED;
              row_d   = ROW_W'(in_row_symbol_i);
              col_d   = ROW_W'(in_column_symbol_i);
              s_d     = in_entry_score_i;
              n_d     = fill_rd;
              i_d     = '0;
              found_d = 1'b0;
            end
            kng_pkg::KIND_QUERY: begin
              active_d     = 1'b0;
              res_status_d = kng_pkg::ST_REJECTED;
              code_d = in_query_code_i;
              lim_d  = LIM_W'(1);
              k_d    = '0;
              pt_we    = !thr_bad;
              pt_idx_w = DEP_W'(q_eff - WORD_W'(1));
              pt_wd    = SUM_W'(thr_q);
            end
            kng_pkg::KIND_FETCH: begin
              res_status_d = kng_pkg::ST_EXHAUSTED;
            end
            default: res_status_d = kng_pkg::ST_REJECTED;
          endcase
        end
      end
      // Remove an earlier entry of the same column, shifting the rest down
      kng_pkg::S_RM_RD: begin
        if (i_q < n_q) begin
          mem_re = 1'b1;
        end else begin
          n_d = found_q ? (n_q - FILL_W'(1)) : n_q;
          i_d = n_d;
        end
      end
      kng_pkg::S_RM_CHK: begin
        if (found_q) begin
          mem_we    = 1'b1;
          mem_waddr = {row_q, ROW_W'(i_q - FILL_W'(1))};
          mem_wdata = rd_q;
        end else if (rd_col == col_q) begin
          found_d = 1'b1;
        end
        i_d = i_q + FILL_W'(1);
      end
      // Insert from the tail, moving lower-ranked entries up
      kng_pkg::S_INS_RD: begin
        if (i_q == '0) begin
          mem_we    = 1'b1;
          mem_waddr = {row_q, {ROW_W{1'b0}}};
        end else begin
          mem_re    = 1'b1;
          mem_raddr = {row_q, ROW_W'(i_q - FILL_W'(1))};
        end
      end
      kng_pkg::S_INS_CHK: begin
        mem_we = 1'b1;
        if (ins_after) begin
          mem_wdata = rd_q;
          i_d       = i_q - FILL_W'(1);
        end
      end
      kng_pkg::S_MAX_RD: begin
        mem_re    = 1'b1;
        mem_raddr = {row_q, {ROW_W{1'b0}}};
        fill_we   = 1'b1;
      end
      kng_pkg::S_MAX_WR: begin
        rmax_we = 1'b1;
        best_d  = -8'sd128;
        i_d     = '0;
      end
      // Sweep the row maxima for the table maximum
      kng_pkg::S_BEST: begin
        if (fill_rd != '0 && rmax_rd > best_q) best_d = rmax_rd;
        i_d = i_q + FILL_W'(1);
      end
      // Bound the code by alphabet^q, saturating
      kng_pkg::S_LIM: begin
        if (k_q < q_eff) begin
          lim_d = lim_nx;
          k_d   = k_q + WORD_W'(1);
        end else begin
          pos_d = DEP_W'(q_eff - WORD_W'(1));
          rem_d = '0;
          bit_d = '0;
        end
      end
      // Peel digits from the least significant end, one quotient bit a cycle
      kng_pkg::S_DIV: begin
        code_d = {code_q[CODE_W-2:0], div_ge};
        rem_d  = rem_nx;
        bit_d  = bit_q + BIT_W'(1);
        if (int'(bit_q) == CODE_W - 1) begin
          dig_we = 1'b1;
          rem_d  = '0;
          bit_d  = '0;
          if (pos_q != '0) begin
            pt_we    = 1'b1;
            pt_idx_w = pos_q - DEP_W'(1);
            pos_d    = pos_q - DEP_W'(1);
          end else begin
            q_init       = 1'b1;
            depth_d      = '0;
            active_d     = 1'b1;
            res_status_d = kng_pkg::ST_ACCEPTED;
          end
        end
      end
      kng_pkg::S_F_LOAD: begin
        i_d = branch_q[depth_q];
      end
      kng_pkg::S_F_TEST: begin
        mem_raddr = {dig_cur, i_q[ROW_W-1:0]};
        if (f_over) begin
          active_d = 1'b0;
        end else if (f_more) begin
          mem_re = 1'b1;
        end else begin
          br_we = 1'b1;
          if (depth_q == '0) active_d = 1'b0;
          else depth_d = depth_q - DEP_W'(1);
        end
      end
      kng_pkg::S_F_EVAL: begin
        if (f_skip) begin
          i_d = i_q + FILL_W'(1);
        end else if (f_hit) begin
          br_we = 1'b1;
          br_wd = i_q + FILL_W'(1);
          if (f_leaf) begin
            res_status_d = kng_pkg::ST_FOUND;
            res_code_d   = ext_code;
            res_score_d  = ns[kng_pkg::OSCORE_W-1:0];
          end else begin
            step_we = 1'b1;
            br1_we  = 1'b1;
            depth_d = depth_q + DEP_W'(1);
          end
        end else begin
          br_we = 1'b1;
          if (depth_q == '0) active_d = 1'b0;
          else depth_d = depth_q - DEP_W'(1);
        end
      end
      kng_pkg::S_EMIT: ;
      default: ;
    endcase
    // Register writes end any running search
    if (cfg_we_i && (cfg_index_i == kng_pkg::CFG_ALPHABET ||
                     cfg_index_i == kng_pkg::CFG_WORD_LEN ||
                     cfg_index_i == kng_pkg::CFG_THRESHOLD)) begin
      active_d = 1'b0;
    end
  end

  // Table memory: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= mem[mem_raddr];
  end

  // Search stacks and query digits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_WORD; j++) begin
        digit_q[j]  <= '0;
        pt_q[j]     <= '0;
        branch_q[j] <= '0;
        pscore_q[j] <= '0;
        pcode_q[j]  <= '0;
      end
    end else begin
      if (dig_we) digit_q[dig_idx] <= digit_new;
      if (pt_we) pt_q[pt_idx_w] <= pt_wd;
      if (br_we) branch_q[depth_q] <= br_wd;
      if (br1_we) branch_q[depth_q + DEP_W'(1)] <= '0;
      if (step_we) begin
        pcode_q[depth_q + DEP_W'(1)]  <= ext_code;
        pscore_q[depth_q + DEP_W'(1)] <= ns;
      end
      if (q_init) begin
        branch_q[0] <= '0;
        pscore_q[0] <= '0;
        pcode_q[0]  <= '0;
      end
    end
  end

  // Row lengths and row maxima
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_ALPHABET; j++) begin
        fill_q[j] <= '0;
        rmax_q[j] <= '0;
      end
    end else begin
      if (fill_we) fill_q[row_q] <= fill_wd;
      if (rmax_we) rmax_q[row_q] <= rd_score;
    end
  end

  // Control state, configuration and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= kng_pkg::S_IDLE;
      alph_q   <= kng_pkg::RST_ALPHABET;
      wlen_q   <= kng_pkg::RST_WORD_LEN;
      thr_q    <= kng_pkg::RST_THRESHOLD;
      best_q   <= -8'sd128;
      depth_q  <= '0;
      active_q <= 1'b0;
      row_q <= '0; col_q <= '0; s_q <= '0;
      n_q <= '0; i_q <= '0; found_q <= 1'b0;
      k_q <= '0; pos_q <= '0; lim_q <= '0;
      code_q <= '0; rem_q <= '0; bit_q <= '0;
      res_status_q <= kng_pkg::ST_LOADED;
      res_code_q   <= '0;
      res_score_q  <= '0;
    end else begin
      state_q  <= state_d;
      best_q   <= best_d;
      depth_q  <= depth_d;
      active_q <= active_d;
      row_q <= row_d; col_q <= col_d; s_q <= s_d;
      n_q <= n_d; i_q <= i_d; found_q <= found_d;
      k_q <= k_d; pos_q <= pos_d; lim_q <= lim_d;
      code_q <= code_d; rem_q <= rem_d; bit_q <= bit_d;
      res_status_q <= res_status_d;
      res_code_q   <= res_code_d;
      res_score_q  <= res_score_d;
      // Take register writes
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          kng_pkg::CFG_ALPHABET:  alph_q <= cfg_data_i[5:0];
          kng_pkg::CFG_WORD_LEN:  wlen_q <= cfg_data_i[3:0];
          kng_pkg::CFG_THRESHOLD: thr_q  <= $signed(cfg_data_i);
          default: ;
        endcase
      end
    end
  end

  // Output register: hold while stalled, load when the slot frees
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == kng_pkg::S_EMIT && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == kng_pkg::S_EMIT && slot_free) begin
      out_status_q <= res_status_q;
      out_code_q   <= res_code_q;
      out_score_q  <= res_score_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_status_o         = out_status_q;
  assign out_neighbor_code_o  = out_code_q;
  assign out_neighbor_score_o = out_score_q;

endmodule

FILE: src/kng_checker.sv
// ----------------------------------------------------------------------------
// kng_checker
// Port-level checks for the k-mer neighborhood generator.
// ----------------------------------------------------------------------------
module kng_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic [1:0]                        in_kind_i,
  input logic [4:0]                        in_row_symbol_i,
  input logic [4:0]                        in_column_symbol_i,
  input logic signed [7:0]                 in_entry_score_i,
  input logic [kng_pkg::CODE_W-1:0]        in_query_code_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [2:0]                        out_status_o,
  input logic [kng_pkg::CODE_W-1:0]        out_neighbor_code_o,
  input logic signed [kng_pkg::OSCORE_W-1:0] out_neighbor_score_o
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_status_o) &&
      $stable(out_neighbor_code_o) && $stable(out_neighbor_score_o))
    else $error("stalled result word changed");

  // A stalled input word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_kind_i) &&
      $stable(in_row_symbol_i) && $stable(in_column_symbol_i) &&
      $stable(in_entry_score_i) && $stable(in_query_code_i))
    else $error("stalled input word changed");

  // Only a found neighbor carries code and score
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o != 3'(kng_pkg::ST_FOUND)) |->
      (out_neighbor_code_o == '0) && (out_neighbor_score_o == '0))
    else $error("non-neighbor result with nonzero payload");

  // An accepted word always leaves the block busy in the cycle after it
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");

endmodule

bind kmer_neighborhood_generator kng_checker u_kng_checker (.*);

FILE: tb/tb_kmer_neighborhood_generator.sv
// ----------------------------------------------------------------------------
// tb_kmer_neighborhood_generator
// Self-checking bench for the word neighborhood generator: loads score
// entries, starts queries and fetches neighbors under random handshake gaps
// and output stalls, and compares every result word with a predictor.
// ----------------------------------------------------------------------------
module tb_kmer_neighborhood_generator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int ITEM_GOAL = 1700;
  localparam int CODE_W = kng_pkg::CODE_W;
  localparam int OSCORE_W = kng_pkg::OSCORE_W;
  localparam int CFG_W = kng_pkg::CFG_W;

  typedef struct {
    kng_pkg::status_e            st;
    logic [CODE_W-1:0]           code;
    logic signed [OSCORE_W-1:0]  score;
  } nbr_result_t;

  // Neighborhood predictor and store of expected result words
  class kmer_scoreboard;
    int tab_col[32][32];
    int tab_scr[32][32];
    int fill[32];
    int best;
    int digit[8], pthr[8], bidx[8], pscore[8];
    longint unsigned pcode;
    int lvl;
    bit active;
    int alpha_reg, word_reg, thr_reg;
    nbr_result_t expected_q[$];
    int mismatches, found, loads, queries, fetches;

    function new();
      foreach (fill[i]) fill[i] = 0;
      foreach (digit[i]) begin
        digit[i] = 0; pthr[i] = 0; bidx[i] = 0; pscore[i] = 0;
      end
      best = -128; pcode = 0; lvl = 0; active = 0;
      alpha_reg = kng_pkg::RST_ALPHABET;
      word_reg = kng_pkg::RST_WORD_LEN;
      thr_reg = kng_pkg::RST_THRESHOLD;
      mismatches = 0; found = 0; loads = 0; queries = 0; fetches = 0;
    endfunction

    function int eff_alpha();
      return (alpha_reg < 2) ? 2 : (alpha_reg > 32) ? 32 : alpha_reg;
    endfunction

    function int eff_word();
      return (word_reg < 1) ? 1 : (word_reg > 8) ? 8 : word_reg;
    endfunction

    function longint unsigned code_limit();
      longint unsigned lim;
      lim = 1;
      for (int i = 0; i < eff_word(); i++) begin
        lim = lim * eff_alpha();
        if (lim > (64'd1 << 41)) lim = 64'd1 << 41;
      end
      return lim;
    endfunction

    function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] v);
      case (idx)
        kng_pkg::CFG_ALPHABET:  begin alpha_reg = v[5:0]; active = 0; end
        kng_pkg::CFG_WORD_LEN:  begin word_reg = v[3:0]; active = 0; end
        kng_pkg::CFG_THRESHOLD: begin thr_reg = $signed(v); active = 0; end
        default: ;
      endcase
    endfunction

    // Replace any entry of the same column, then insert in descending order
    function void load_entry(int row, int col, int s);
      int n, j;
      n = fill[row];
      for (int i = 0; i < n; i++) begin
        if (tab_col[row][i] == col) begin
          for (int k = i; k < n - 1; k++) begin
            tab_col[row][k] = tab_col[row][k+1];
            tab_scr[row][k] = tab_scr[row][k+1];
          end
          n--;
          break;
        end
      end
      j = n;
      for (int i = 0; i < n; i++) begin
        if (tab_scr[row][i] < s || (tab_scr[row][i] == s && tab_col[row][i] > col)) begin
          j = i;
          break;
        end
      end
      for (int k = n; k > j; k--) begin
        tab_col[row][k] = tab_col[row][k-1];
        tab_scr[row][k] = tab_scr[row][k-1];
      end
      tab_col[row][j] = col;
      tab_scr[row][j] = s;
      fill[row] = n + 1;
      best = -128;
      for (int i = 0; i < 32; i++)
        if (fill[i] > 0 && tab_scr[i][0] > best) best = tab_scr[i][0];
    endfunction

    function kng_pkg::status_e start_query(longint unsigned code);
      int a, q, mx;
      a = eff_alpha();
      q = eff_word();
      active = 0;
      if (thr_reg > q * best) return kng_pkg::ST_REJECTED;
      if (code >= code_limit()) return kng_pkg::ST_REJECTED;
      for (int i = 0; i < q; i++) begin
        digit[q-1-i] = code % a;
        code = code / a;
      end
      pthr[q-1] = thr_reg;
      for (int i = q - 1; i > 0; i--) begin
        mx = (fill[digit[i]] > 0) ? tab_scr[digit[i]][0] : 0;
        pthr[i-1] = pthr[i] - mx;
      end
      lvl = 0; bidx[0] = 0; pscore[0] = 0; pcode = 0; active = 1;
      return kng_pkg::ST_ACCEPTED;
    endfunction

    // Resume the pruned depth-first walk until the next neighbor or the end
    function kng_pkg::status_e next_neighbor(output longint unsigned code,
                                             output int score);
      int a, q, d, row, i, ns;
      a = eff_alpha();
      q = eff_word();
      code = 0;
      score = 0;
      if (!active) return kng_pkg::ST_EXHAUSTED;
      forever begin
        d = lvl & 15;
        if (d >= q) begin
          active = 0;
          return kng_pkg::ST_EXHAUSTED;
        end
        row = digit[d] % 32;
        i = bidx[d];
        while (i < fill[row] && tab_col[row][i] >= a) i++;
        if (i < fill[row] && pscore[d] + tab_scr[row][i] >= pthr[d]) begin
          ns = pscore[d] + tab_scr[row][i];
          bidx[d] = i + 1;
          if (d + 1 == q) begin
            code = pcode * a + tab_col[row][i];
            score = ns;
            return kng_pkg::ST_FOUND;
          end
          pcode = pcode * a + tab_col[row][i];
          pscore[d+1] = ns;
          bidx[d+1] = 0;
          lvl = d + 1;
        end else begin
          bidx[d] = i;
          if (d == 0) begin
            active = 0;
            return kng_pkg::ST_EXHAUSTED;
          end
          lvl = d - 1;
          pcode = pcode / a;
        end
      end
    endfunction

    function void note_input(logic [1:0] kind, logic [4:0] row, logic [4:0] col,
                             logic signed [7:0] s, logic [CODE_W-1:0] code);
      nbr_result_t r;
      longint unsigned c;
      int sc;
      r.st = kng_pkg::ST_REJECTED;
      r.code = '0;
      r.score = '0;
      case (kind)
        kng_pkg::KIND_LOAD: begin
          active = 0;
          load_entry(row, col, s);
          r.st = kng_pkg::ST_LOADED;
          loads++;
        end
        kng_pkg::KIND_QUERY: begin
          r.st = start_query(code);
          queries++;
        end
        kng_pkg::KIND_FETCH: begin
          r.st = next_neighbor(c, sc);
          r.code = c[CODE_W-1:0];
          r.score = sc[OSCORE_W-1:0];
          fetches++;
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [2:0] st, logic [CODE_W-1:0] code,
                               logic signed [OSCORE_W-1:0] score);
      nbr_result_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: status %0d code %0h score %0d",
                   st, code, score);
        return;
      end
      e = expected_q.pop_front();
      if (e.st == kng_pkg::ST_FOUND) found++;
      if (st !== e.st || code !== e.code || score !== e.score) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected status %0d code %0h score %0d, got %0d %0h %0d",
                   e.st, e.code, e.score, st, code, score);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [kng_pkg::CFGIDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o;
  logic [1:0] in_kind_i;
  logic [4:0] in_row_symbol_i, in_column_symbol_i;
  logic signed [7:0] in_entry_score_i;
  logic [CODE_W-1:0] in_query_code_i;
  logic out_valid_o, out_stall_i;
  logic [2:0] out_status_o;
  logic [CODE_W-1:0] out_neighbor_code_o;
  logic signed [OSCORE_W-1:0] out_neighbor_score_o;

  kmer_scoreboard sb;
  int cycles;
  int sent;
  bit no_gaps;

  kmer_neighborhood_generator DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_kind_i, .in_row_symbol_i, .in_column_symbol_i,
    .in_entry_score_i, .in_query_code_i,
    .out_valid_o, .out_stall_i, .out_status_o, .out_neighbor_code_o,
    .out_neighbor_score_o
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    sb = new();
    cycles = 0;
    sent = 0;
    no_gaps = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_kind_i = kng_pkg::KIND_LOAD;
    in_row_symbol_i = '0;
    in_column_symbol_i = '0;
    in_entry_score_i = '0;
    in_query_code_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog on the cycle count
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Check every accepted result word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(out_status_o, out_neighbor_code_o, out_neighbor_score_o);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver stall: runs of random length, with stall-free stretches
  initial begin
    int len;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      len = pick_gap();
      out_stall_i <= (len != 0);
      repeat (len == 0 ? $urandom_range(1, 12) : len) @(posedge clk_i);
    end
  end

  // Send one word; the expectation is noted at the accepting edge
  task automatic send_word(logic [1:0] kind, logic [4:0] row, logic [4:0] col,
                           logic [7:0] s, logic [CODE_W-1:0] code);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_kind_i <= kind;
    in_row_symbol_i <= row;
    in_column_symbol_i <= col;
    in_entry_score_i <= s;
    in_query_code_i <= code;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(kind, row, col, s, code);
    sent++;
  endtask

  // Hold the sender until every expected word is back, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.write_reg(idx, v);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CODE_W-1:0] rand_code();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    int q, thr, n, pick;
    logic [CFG_W-1:0] v;
    logic [CODE_W-1:0] code;
    @(posedge rst_ni);
    @(posedge clk_i);

    // Directed: fetch with no search, rejected query on an empty table, unknown kind
    send_word(kng_pkg::KIND_FETCH, 0, 0, 0, 0);
    send_word(kng_pkg::KIND_QUERY, 0, 0, 0, 0);
    send_word(KIND_NONE, 5'h1f, 5'h1f, 8'hff, '1);
    drain();
    write_reg(kng_pkg::CFG_ALPHABET, 11'd4);
    write_reg(kng_pkg::CFG_WORD_LEN, 11'd2);
    write_reg(kng_pkg::CFG_THRESHOLD, 11'd0);
    // Small table, a column outside the alphabet, an empty row, a reloaded tie
    send_word(kng_pkg::KIND_LOAD, 0, 0, 8'sd5, 0);
    send_word(kng_pkg::KIND_LOAD, 0, 1, -8'sd2, 0);
    send_word(kng_pkg::KIND_LOAD, 0, 2, 8'sd1, 0);
    send_word(kng_pkg::KIND_LOAD, 0, 3, -8'sd128, 0);
    send_word(kng_pkg::KIND_LOAD, 1, 31, 8'sd127, 0);
    send_word(kng_pkg::KIND_LOAD, 1, 0, 8'sd3, 0);
    send_word(kng_pkg::KIND_LOAD, 0, 1, 8'sd5, 0);
    send_word(kng_pkg::KIND_QUERY, 0, 0, 0, 40'd1);
    repeat (6) send_word(kng_pkg::KIND_FETCH, 0, 0, 0, 0);
    send_word(kng_pkg::KIND_QUERY, 0, 0, 0, 40'd2);
    send_word(kng_pkg::KIND_FETCH, 0, 0, 0, 0);
    send_word(kng_pkg::KIND_QUERY, 0, 0, 0, 40'd16);
    send_word(kng_pkg::KIND_QUERY, 0, 0, 0, '1);
    drain();
    write_reg(kng_pkg::CFG_THRESHOLD, 11'd1016);
    send_word(kng_pkg::KIND_QUERY, 0, 0, 0, 40'd0);
    drain();
    write_reg(kng_pkg::CFG_THRESHOLD, 11'h400);
    write_reg(CFG_SPARE, 11'h7ff);

    // Random phases: loads, a settled register set, then queries with fetches
    while (sent < ITEM_GOAL) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      n = $urandom_range(0, 24);
      for (int i = 0; i < n; i++) begin
        pick = $urandom_range(0, 9);
        send_word(kng_pkg::KIND_LOAD,
                  pick < 8 ? $urandom_range(0, sb.eff_alpha() - 1) : $urandom(),
                  pick < 7 ? $urandom_range(0, sb.eff_alpha() - 1) : $urandom(),
                  $urandom(), rand_code());
      end
      drain();
      pick = $urandom_range(0, 19);
      v = $urandom();
      if (pick < 12) v[5:0] = $urandom_range(2, 8);
      else if (pick < 16) v[5:0] = 32;
      else if (pick < 18) v[5:0] = $urandom_range(0, 1);
      else v[5:0] = 6'h3f;
      write_reg(kng_pkg::CFG_ALPHABET, v);
      pick = $urandom_range(0, 19);
      v = $urandom();
      if (pick < 14) v[3:0] = $urandom_range(1, 4);
      else if (pick < 17) v[3:0] = 8;
      else if (pick < 18) v[3:0] = 0;
      else v[3:0] = $urandom_range(9, 15);
      write_reg(kng_pkg::CFG_WORD_LEN, v);
      q = sb.eff_word();
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        thr = q * sb.best - $urandom_range(0, 12 * q);
        if (thr < -1024) thr = -1024;
        if (thr > 1016) thr = 1016;
        v = thr[CFG_W-1:0];
      end else if (pick < 17) begin
        v = 11'h400;
      end else begin
        v = $urandom();
      end
      write_reg(kng_pkg::CFG_THRESHOLD, v);
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 9) == 0) code = rand_code();
        else code = {$urandom(), $urandom()} % sb.code_limit();
        send_word(kng_pkg::KIND_QUERY, $urandom(), $urandom(), $urandom(), code);
        repeat ($urandom_range(1, 20)) begin
          pick = $urandom_range(0, 39);
          if (pick == 0)
            send_word(KIND_NONE, $urandom(), $urandom(), $urandom(), rand_code());
          else if (pick == 1)
            send_word(kng_pkg::KIND_LOAD, $urandom(), $urandom(), $urandom(),
                      rand_code());
          else
            send_word(kng_pkg::KIND_FETCH, $urandom(), $urandom(), $urandom(),
                      rand_code());
        end
      end
      drain();
    end

    drain();
    sb.mismatches += sb.expected_q.size();
    $display("covered %0d loads, %0d queries, %0d fetches; %0d neighbors found",
             sb.loads, sb.queries, sb.fetches, sb.found);
    $display("registers swept over alphabet, word length and threshold extremes");
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
